// File: sv/swzs_pkg.sv
// ----------------------------------------------------------------------------
// swzs_pkg
// shared types and constants of the sliding window statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package swzs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SUM_W       = 35;
  localparam int SQ_W        = 58;
  localparam int WL_W        = 11;
  localparam int THR_W       = 32;
  localparam int INV_W       = 32;
  localparam int DG_W        = 36;
  localparam int DIV_W       = 72;
  localparam int DVS_W       = 58;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FLAT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_THRESHOLD = 2'd1;

  localparam logic [WL_W-1:0]  WL_RESET  = 11'd64;
  localparam logic [THR_W-1:0] THR_RESET = 32'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] old;
    logic signed [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]               sq;
    logic                          tainted;
    logic                          had_window;
    logic                          final_req;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quo;
    logic [DVS_W-1:0]  rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: sv/swzs_front.sv
// ----------------------------------------------------------------------------
// swzs_front
// takes samples, keeps the delay line and running sums, queues full windows
// ----------------------------------------------------------------------------
`default_nettype none

module swzs_front #(
  parameter int MAX_WINDOW = 1024,
  parameter int AW         = 10,
  parameter int MW         = 11
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire  signed [swzs_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire                                    in_invalid,
  input  wire                                    in_final,
  input  wire  [MW-1:0]                          m,
  input  wire                                    clear,
  input  wire                                    q_full,
  output logic                                   q_push,
  output swzs_pkg::job_t                         q_job
);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_UPD  = 1'b1;
  localparam int   EW     = AW + 2;

  logic state_r;
  logic signed [swzs_pkg::SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic signed [swzs_pkg::SAMPLE_BITS-1:0] mem_q_r;
  logic [AW-1:0] wp_r;
  logic signed [swzs_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [swzs_pkg::SQ_W-1:0] sq_r, sq_nxt;
  logic [MW-1:0] seen_r, seen_nxt;
  logic [MW-1:0] since_r, si;
  logic [MW:0] si_inc;
  logic signed [swzs_pkg::SAMPLE_BITS-1:0] x_r, x_in, old;
  logic signed [2*swzs_pkg::SAMPLE_BITS-1:0] xsq, xsq_r, oldsq;
  logic tainted_r, had_r, final_r;
  logic accept;
  logic [EW-1:0] wp_e, m_e, rd_e;
  logic [AW-1:0] rd_addr;

  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign x_in     = in_invalid ? '0 : in_sample;
  assign xsq      = x_in * x_in;
  assign si       = in_invalid ? '0 : since_r;
  assign si_inc   = {1'b0, si} + 1'b1;

  // circular read address of the sample leaving the window
  assign wp_e    = EW'(wp_r);
  assign m_e     = EW'(m);
  assign rd_e    = (wp_e >= m_e) ? (wp_e - m_e) : (wp_e + EW'(MAX_WINDOW) - m_e);
  assign rd_addr = rd_e[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q_r <= mem[rd_addr];
    end
    if (state_r == F_UPD) begin
      mem[wp_r] <= x_r;
    end
  end

  assign old      = had_r ? mem_q_r : '0;
  assign oldsq    = old * old;
  assign sum_nxt  = sum_r + swzs_pkg::SUM_W'(x_r) - swzs_pkg::SUM_W'(old);
  assign sq_nxt   = sq_r + swzs_pkg::SQ_W'($unsigned(xsq_r))
                  - swzs_pkg::SQ_W'($unsigned(oldsq));
  assign seen_nxt = (seen_r < m) ? seen_r + 1'b1 : seen_r;

  assign q_push           = (state_r == F_UPD) && (seen_nxt == m);
  assign q_job.x          = x_r;
  assign q_job.old        = old;
  assign q_job.sum        = sum_nxt;
  assign q_job.sq         = sq_nxt;
  assign q_job.tainted    = tainted_r;
  assign q_job.had_window = had_r;
  assign q_job.final_req  = final_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= x_in;
      xsq_r     <= xsq;
      tainted_r <= (si < m);
      had_r     <= (seen_r >= m);
      final_r   <= in_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      state_r <= F_IDLE;
      wp_r    <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      seen_r  <= '0;
      since_r <= MW'(MAX_WINDOW);
    end else begin
      if (accept) begin
        state_r <= F_UPD;
        since_r <= (si_inc > (MW+1)'(MAX_WINDOW)) ? MW'(MAX_WINDOW) : si_inc[MW-1:0];
      end
      if (state_r == F_UPD) begin
        state_r <= F_IDLE;
        if (final_r) begin
          wp_r    <= '0;
          sum_r   <= '0;
          sq_r    <= '0;
          seen_r  <= '0;
          since_r <= MW'(MAX_WINDOW);
        end else begin
          wp_r   <= (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
          sum_r  <= sum_nxt;
          sq_r   <= sq_nxt;
          seen_r <= seen_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/swzs_queue.sv
// ----------------------------------------------------------------------------
// swzs_queue
// two-entry queue of window jobs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module swzs_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  swzs_pkg::job_t  push_job,
  input  wire             pop,
  output swzs_pkg::job_t  head,
  output logic            full,
  output logic            empty
);

  swzs_pkg::job_t ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("job queue count out of range");

endmodule

`default_nettype wire

// File: sv/swzs_div.sv
// ----------------------------------------------------------------------------
// swzs_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module swzs_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  swzs_pkg::div_req_t  req,
  output swzs_pkg::div_rsp_t  rsp
);

  localparam int CW = $clog2(swzs_pkg::DIV_W + 1);

  logic [swzs_pkg::DIV_W-1:0] quo_r;
  logic [swzs_pkg::DVS_W-1:0] rem_r, dvs_r;
  logic [swzs_pkg::DVS_W:0]   sh;
  logic                       ge;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, done_r;

  assign sh = {rem_r, quo_r[swzs_pkg::DIV_W-1]};
  assign ge = sh >= {1'b0, dvs_r};

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? swzs_pkg::DVS_W'(sh - {1'b0, dvs_r}) : sh[swzs_pkg::DVS_W-1:0];
      quo_r <= {quo_r[swzs_pkg::DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(swzs_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/swzs_back.sv
// ----------------------------------------------------------------------------
// swzs_back
// per-window mean, squared deviation and inverse norm, record output
// ----------------------------------------------------------------------------
`default_nettype none

module swzs_back #(
  parameter int MW = 11
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  swzs_pkg::job_t                   q_head,
  input  wire                              q_empty,
  output logic                             q_pop,
  input  wire  [MW-1:0]                    m,
  input  wire  [swzs_pkg::THR_W-1:0]       thr,
  output swzs_pkg::div_req_t               div_req,
  input  swzs_pkg::div_rsp_t               div_rsp,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [swzs_pkg::SAMPLE_BITS-1:0] out_mean,
  output logic [swzs_pkg::INV_W-1:0]       out_inv,
  output logic [1:0]                       out_status,
  output logic signed [swzs_pkg::SAMPLE_BITS-1:0] out_df,
  output logic signed [swzs_pkg::DG_W-1:0] out_dg,
  output logic                             out_last
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_MEAN  = 4'd1;
  localparam logic [3:0] B_SQ    = 4'd2;
  localparam logic [3:0] B_SSD   = 4'd3;
  localparam logic [3:0] B_CLS   = 4'd4;
  localparam logic [3:0] B_INV   = 4'd5;
  localparam logic [3:0] B_ROOT  = 4'd6;
  localparam logic [3:0] B_EMIT1 = 4'd7;
  localparam logic [3:0] B_EMIT2 = 4'd8;

  localparam int SB = swzs_pkg::SAMPLE_BITS;
  localparam int PW = 2 * swzs_pkg::SUM_W;

  logic [3:0] state_r;
  swzs_pkg::job_t job_r;
  logic [swzs_pkg::SUM_W-1:0] abs_r;
  logic [PW-1:0] acc_r, mcand_r;
  logic [swzs_pkg::SUM_W-1:0] mplier_r;
  logic [5:0] cnt_r;
  logic signed [SB-1:0] mean_r, pend_mean_r;
  logic [swzs_pkg::INV_W-1:0] inv_r, pend_inv_r;
  logic [1:0] st_r, pend_st_r;
  logic [swzs_pkg::SQ_W-1:0] ssd_r;
  logic [63:0] rad_r;
  logic [31:0] root_r;
  logic [32:0] srem_r;
  logic start_r;
  logic [swzs_pkg::DIV_W-1:0] dvd_r;
  logic [swzs_pkg::DVS_W-1:0] dvs_r;
  logic out_valid_r;
  logic slot_free;

  // floor mean from the magnitude quotient
  logic [swzs_pkg::SUM_W:0] qmag;
  logic signed [swzs_pkg::SUM_W+1:0] mean_full;
  // ceil of sum squared over m, and the deviation it leaves
  logic [swzs_pkg::DIV_W:0] ceil_q;
  logic [swzs_pkg::THR_W+MW-1:0] flat_lim;
  // integer square root step
  logic [34:0] r4, trial;
  logic        r_ge;
  // step terms of the record
  logic signed [SB:0] diff;
  logic signed [swzs_pkg::DG_W-1:0] dg;

  assign qmag = {1'b0, div_rsp.quo[swzs_pkg::SUM_W-1:0]}
              + ((job_r.sum < 0 && div_rsp.rem != '0) ? 1'b1 : 1'b0);
  assign mean_full = (job_r.sum < 0) ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign ceil_q = {1'b0, div_rsp.quo} + ((div_rsp.rem != '0) ? 1'b1 : 1'b0);
  assign flat_lim = thr * m;

  assign r4    = {srem_r, rad_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};
  assign r_ge  = r4 >= trial;

  assign diff = (SB+1)'(job_r.x) - (SB+1)'(job_r.old);
  assign dg   = swzs_pkg::DG_W'(job_r.x) - swzs_pkg::DG_W'(mean_r)
              + swzs_pkg::DG_W'(job_r.old) - swzs_pkg::DG_W'(pend_mean_r);

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  assign div_req.start    = start_r;
  assign div_req.dividend = dvd_r;
  assign div_req.divisor  = dvs_r;

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          job_r <= q_head;
          abs_r <= (q_head.sum < 0) ? swzs_pkg::SUM_W'(-q_head.sum)
                                    : swzs_pkg::SUM_W'(q_head.sum);
          dvd_r <= (q_head.sum < 0) ? swzs_pkg::DIV_W'(-q_head.sum)
                                    : swzs_pkg::DIV_W'(q_head.sum);
          dvs_r <= swzs_pkg::DVS_W'(m);
        end
      end
      B_MEAN: begin
        if (div_rsp.done) begin
          mean_r   <= mean_full[SB-1:0];
          acc_r    <= '0;
          mcand_r  <= PW'(abs_r);
          mplier_r <= abs_r;
          cnt_r    <= 6'(swzs_pkg::SUM_W);
        end
      end
      B_SQ: begin
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r  <= {mcand_r[PW-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[swzs_pkg::SUM_W-1:1]};
        cnt_r    <= cnt_r - 1'b1;
        dvd_r    <= swzs_pkg::DIV_W'(acc_r + (mplier_r[0] ? mcand_r : '0));
      end
      B_SSD: begin
        if (div_rsp.done) begin
          ssd_r <= (ceil_q > (swzs_pkg::DIV_W+1)'(job_r.sq)) ? '0
                 : swzs_pkg::SQ_W'((swzs_pkg::DIV_W+1)'(job_r.sq) - ceil_q);
        end
      end
      B_CLS: begin
        inv_r <= '0;
        if (job_r.tainted) begin
          st_r <= swzs_pkg::ST_INVALID;
        end else if (ssd_r <= swzs_pkg::SQ_W'(flat_lim)) begin
          st_r <= swzs_pkg::ST_FLAT;
        end else begin
          st_r <= swzs_pkg::ST_NORMAL;
          if (ssd_r <= swzs_pkg::SQ_W'(1)) inv_r <= '1;
        end
        dvd_r <= swzs_pkg::DIV_W'(1) << 64;
        dvs_r <= ssd_r;
      end
      B_INV: begin
        if (div_rsp.done) begin
          rad_r  <= div_rsp.quo[63:0];
          root_r <= '0;
          srem_r <= '0;
          cnt_r  <= 6'd32;
        end
      end
      B_ROOT: begin
        rad_r  <= {rad_r[61:0], 2'b00};
        srem_r <= r_ge ? 33'(r4 - trial) : r4[32:0];
        root_r <= {root_r[30:0], r_ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) inv_r <= {root_r[30:0], r_ge};
      end
      B_EMIT1: begin
        if (!job_r.had_window || slot_free) begin
          pend_mean_r <= mean_r;
          pend_inv_r  <= inv_r;
          pend_st_r   <= st_r;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == B_EMIT1 && job_r.had_window && slot_free) begin
      out_mean   <= pend_mean_r;
      out_inv    <= pend_inv_r;
      out_status <= pend_st_r;
      out_df     <= diff[SB:1];
      out_dg     <= dg;
      out_last   <= 1'b0;
    end else if (state_r == B_EMIT2 && slot_free) begin
      out_mean   <= pend_mean_r;
      out_inv    <= pend_inv_r;
      out_status <= pend_st_r;
      out_df     <= '0;
      out_dg     <= '0;
      out_last   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            start_r <= 1'b1;
            state_r <= B_MEAN;
          end
        end
        B_MEAN: begin
          if (div_rsp.done) state_r <= B_SQ;
        end
        B_SQ: begin
          if (cnt_r == 6'd1) begin
            start_r <= 1'b1;
            state_r <= B_SSD;
          end
        end
        B_SSD: begin
          if (div_rsp.done) state_r <= B_CLS;
        end
        B_CLS: begin
          if (!job_r.tainted && ssd_r > swzs_pkg::SQ_W'(flat_lim)
              && ssd_r > swzs_pkg::SQ_W'(1)) begin
            start_r <= 1'b1;
            state_r <= B_INV;
          end else begin
            state_r <= B_EMIT1;
          end
        end
        B_INV: begin
          if (div_rsp.done) state_r <= B_ROOT;
        end
        B_ROOT: begin
          if (cnt_r == 6'd1) state_r <= B_EMIT1;
        end
        B_EMIT1: begin
          if (!job_r.had_window || slot_free) begin
            if (job_r.had_window) out_valid_r <= 1'b1;
            state_r <= job_r.final_req ? B_EMIT2 : B_IDLE;
          end
        end
        B_EMIT2: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  a_inv_zero_unless_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status != swzs_pkg::ST_NORMAL |-> out_inv == '0)
    else $error("inverse norm set on a tainted or flat window");

  a_last_has_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last |-> out_df == '0 && out_dg == '0)
    else $error("final record carries step terms");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

// File: sv/sliding_window_znorm_stats.sv
// ----------------------------------------------------------------------------
// sliding_window_znorm_stats
// sliding window mean, squared deviation and inverse norm of a sample stream
// ----------------------------------------------------------------------------
// in_*  : one sample per item; tdata holds the Q12.12 sample, tuser marks it
//         invalid (used as zero, taints its windows), tlast ends the series
// out_* : one record per full window, emitted when the next sample arrives;
//         the series end flushes the last window with out_tlast set
// cfg_* : register writes (index 0 window length, index 1 flat threshold),
//         taken every cycle; a window length write restarts the series
// a sample that completes no window passes the idle and update states of
// the front part; in the back part a window takes two passes of the
// shared divider (mean, squared sum over m) around a shift-add squarer,
// and a normal window with deviation above one a third pass (2^64 over deviation) and a square root
// a two-entry job queue lets the front keep taking samples while the back
// works; a stalled receiver holds the output register and then the back
// reset clears the series state, window length to 64, threshold to 2;
// the delay line is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_znorm_stats #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [23:0]  in_tdata,   // sample[23:0]
  input  wire  [0:0]   in_tuser,   // invalid[0]
  input  wire          in_tlast,
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [119:0] out_tdata,  // window_mean[23:0], inverse_norm[55:24],
                                   // half_difference[79:56], centered_sum[115:80]
  output logic [1:0]   out_tuser,  // status[1:0]
  output logic         out_tlast,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [swzs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [swzs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int MW = $clog2(MAX_WINDOW + 1);

  logic [swzs_pkg::WL_W-1:0]  wl_r;
  logic [swzs_pkg::THR_W-1:0] thr_r;
  logic [MW-1:0]              m;
  logic                       cfg_acc, clear;
  logic                       q_push, q_pop, q_full, q_empty;
  swzs_pkg::job_t             q_job, q_head;
  swzs_pkg::div_req_t         div_req;
  swzs_pkg::div_rsp_t         div_rsp;
  logic signed [23:0]         o_mean, o_df;
  logic [31:0]                o_inv;
  logic signed [35:0]         o_dg;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign clear     = cfg_acc && (cfg_index == swzs_pkg::REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r  <= swzs_pkg::WL_RESET;
      thr_r <= swzs_pkg::THR_RESET;
    end else if (cfg_acc) begin
      case (cfg_index)
        swzs_pkg::REG_WINDOW_LENGTH:  wl_r  <= cfg_data[swzs_pkg::WL_W-1:0];
        swzs_pkg::REG_FLAT_THRESHOLD: thr_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // zero length runs as one, anything past the delay line as its depth
  assign m = (wl_r == '0) ? MW'(1)
           : (32'(wl_r) > 32'(MAX_WINDOW)) ? MW'(MAX_WINDOW) : MW'(wl_r);

  swzs_front #(.MAX_WINDOW(MAX_WINDOW), .AW(AW), .MW(MW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  (in_tdata),
    .in_invalid (in_tuser[0]),
    .in_final   (in_tlast),
    .m          (m),
    .clear      (clear),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  swzs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  swzs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  swzs_back #(.MW(MW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .m          (m),
    .thr        (thr_r),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_mean   (o_mean),
    .out_inv    (o_inv),
    .out_status (out_tuser),
    .out_df     (o_df),
    .out_dg     (o_dg),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'b0000, o_dg, o_df, o_inv, o_mean};

endmodule

`default_nettype wire
